// ----- rtl/core/hphr_pkg.sv -----
`timescale 1ns / 1ps

package hphr_pkg;

    typedef enum logic [1:0] {
        OP_DSP_READ   = 2'd0,
        OP_DSP_WRITE  = 2'd1,
        OP_HOST_READ  = 2'd2,
        OP_HOST_WRITE = 2'd3
    } op_t;

    localparam logic [5:0] DSP_ADDR_CONTROL = 6'd4;
    localparam logic [5:0] DSP_ADDR_STATUS  = 6'd36;
    localparam logic [5:0] DSP_ADDR_DATA    = 6'd37;

    localparam logic [5:0] HOST_ADDR_CONTROL = 6'd0;
    localparam logic [5:0] HOST_ADDR_COMMAND = 6'd1;
    localparam logic [5:0] HOST_ADDR_STATUS  = 6'd2;
    localparam logic [5:0] HOST_ADDR_VECTOR  = 6'd3;
    localparam logic [5:0] HOST_ADDR_ZERO    = 6'd4;
    localparam logic [5:0] HOST_ADDR_DATA_HI = 6'd6;
    localparam logic [5:0] HOST_ADDR_DATA_LO = 6'd7;

    localparam logic [15:0] EMPTY_DSP_READ   = 16'hBEEF;
    localparam logic [7:0]  EMPTY_HOST_READ  = 8'hBF;
    localparam logic [7:0]  HOST_UNMAPPED    = 8'hFF;

    localparam logic [7:0] VECTOR_NUMBER_RESET  = 8'd15;
    localparam logic [4:0] DSP_CONTROL_RESET    = 5'h00;
    localparam logic [7:0] DSP_STATUS_RESET     = 8'h02;
    localparam logic [7:0] HOST_CONTROL_RESET   = 8'h00;
    localparam logic [7:0] COMMAND_VECTOR_RESET = 8'h16;
    localparam logic [7:0] HOST_STATUS_RESET    = 8'h02;

    typedef struct packed {
        logic [1:0]  operation;
        logic [5:0]  register_address;
        logic [15:0] write_data;
    } access_t;

    typedef struct packed {
        logic [15:0] read_data;
        logic        command_irq;
        logic        transmit_irq;
        logic        receive_irq;
    } result_t;

endpackage

// ----- rtl/core/hphr_if.sv -----
`timescale 1ns / 1ps

interface hphr_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [5:0]  register_address;
    logic [15:0] write_data;

    modport source (output valid, output operation, output register_address,
                    output write_data, input ready);
    modport sink (input valid, input operation, input register_address,
                  input write_data, output ready);
endinterface

interface hphr_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] read_data;
    logic        command_irq;
    logic        transmit_irq;
    logic        receive_irq;

    modport source (output valid, output read_data, output command_irq,
                    output transmit_irq, output receive_irq, input ready);
    modport sink (input valid, input read_data, input command_irq,
                  input transmit_irq, input receive_irq, output ready);
endinterface

// ----- rtl/core/hphr_in_stage.sv -----
`timescale 1ns / 1ps

module hphr_in_stage (
    input  logic             clk,
    input  logic             rst_n,
    hphr_in_if.sink          request,
    input  logic             advance,
    output logic             held_valid,
    output hphr_pkg::access_t held_access
);
    import hphr_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    access_t access_reg;
    logic    take;

    assign request.ready = !valid_reg || advance;
    assign take          = request.valid && request.ready;
    assign valid_next    = take ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            access_reg.operation        <= request.operation;
            access_reg.register_address <= request.register_address;
            access_reg.write_data       <= request.write_data;
        end
    end

    assign held_valid  = valid_reg;
    assign held_access = access_reg;

endmodule

// ----- rtl/core/hphr_port_regs.sv -----
`timescale 1ns / 1ps

module hphr_port_regs (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [7:0]        cfg_data,
    input  logic              advance,
    input  hphr_pkg::access_t access,
    output hphr_pkg::result_t result
);
    import hphr_pkg::*;

    logic [7:0]  vector_number_reg;
    logic [4:0]  dsp_control_reg, dsp_control_next;
    logic [7:0]  dsp_status_reg, dsp_status_next;
    logic [7:0]  host_control_reg, host_control_next;
    logic [7:0]  command_vector_reg, command_vector_next;
    logic [7:0]  host_status_reg, host_status_next;
    logic [15:0] host_tx_reg, host_tx_next;
    logic [15:0] host_rx_reg, host_rx_next;
    logic [15:0] dsp_tx_reg, dsp_tx_next;
    logic [15:0] dsp_rx_reg, dsp_rx_next;

    logic [7:0]  wbyte;
    logic        to_dsp;
    logic        to_host;

    assign wbyte = access.write_data[7:0];

    always_comb
    begin
        dsp_control_next    = dsp_control_reg;
        dsp_status_next     = dsp_status_reg;
        host_control_next   = host_control_reg;
        command_vector_next = command_vector_reg;
        host_status_next    = host_status_reg;
        host_tx_next        = host_tx_reg;
        host_rx_next        = host_rx_reg;
        dsp_tx_next         = dsp_tx_reg;
        dsp_rx_next         = dsp_rx_reg;
        result              = '0;
        to_dsp              = 1'b0;
        to_host             = 1'b0;

        case (op_t'(access.operation))
            OP_DSP_READ:
            begin
                if (access.register_address == DSP_ADDR_CONTROL)
                begin
                    result.read_data = {11'd0, dsp_control_reg};
                end
                else if (access.register_address == DSP_ADDR_STATUS)
                begin
                    result.read_data = {8'd0, dsp_status_reg};
                end
                else if (access.register_address == DSP_ADDR_DATA)
                begin
                    if (!dsp_status_reg[0])
                    begin
                        result.read_data = EMPTY_DSP_READ;
                    end
                    else
                    begin
                        result.read_data   = dsp_rx_reg;
                        dsp_status_next[0] = 1'b0;
                        to_dsp             = !host_status_reg[1];
                    end
                end
            end
            OP_DSP_WRITE:
            begin
                if (access.register_address == DSP_ADDR_CONTROL)
                begin
                    dsp_control_next      = access.write_data[4:0];
                    host_status_next[4:3] = access.write_data[4:3];
                end
                else if (access.register_address == DSP_ADDR_DATA)
                begin
                    dsp_tx_next        = access.write_data;
                    dsp_status_next[1] = 1'b0;
                    to_host            = !host_status_reg[0];
                end
            end
            OP_HOST_READ:
            begin
                case (access.register_address)
                    HOST_ADDR_CONTROL: result.read_data = {8'd0, host_control_reg};
                    HOST_ADDR_COMMAND: result.read_data = {8'd0, command_vector_reg};
                    HOST_ADDR_STATUS:  result.read_data = {8'd0, host_status_reg};
                    HOST_ADDR_VECTOR:  result.read_data = {8'd0, vector_number_reg};
                    HOST_ADDR_ZERO:    result.read_data = 16'd0;
                    HOST_ADDR_DATA_HI:
                    begin
                        if (!host_status_reg[0])
                        begin
                            result.read_data = {8'd0, EMPTY_HOST_READ};
                        end
                        else
                        begin
                            result.read_data = {8'd0, host_rx_reg[15:8]};
                        end
                    end
                    HOST_ADDR_DATA_LO:
                    begin
                        if (!host_status_reg[0])
                        begin
                            result.read_data = {8'd0, EMPTY_HOST_READ};
                        end
                        else
                        begin
                            result.read_data    = {8'd0, host_rx_reg[7:0]};
                            host_status_next[0] = 1'b0;
                            to_host             = !dsp_status_reg[1];
                        end
                    end
                    default: result.read_data = {8'd0, HOST_UNMAPPED};
                endcase
            end
            OP_HOST_WRITE:
            begin
                case (access.register_address)
                    HOST_ADDR_CONTROL:
                    begin
                        host_control_next[4:3] = wbyte[4:3];
                        host_control_next[1:0] = wbyte[1:0];
                        dsp_status_next[4:3]   = wbyte[4:3];
                    end
                    HOST_ADDR_COMMAND:
                    begin
                        command_vector_next[7]   = wbyte[7];
                        command_vector_next[4:0] = wbyte[4:0];
                        dsp_status_next[2]       = wbyte[7];
                        result.command_irq       = wbyte[7] && dsp_control_reg[2];
                    end
                    HOST_ADDR_DATA_HI:
                    begin
                        if (host_status_reg[1])
                        begin
                            host_tx_next[15:8] = wbyte;
                        end
                    end
                    HOST_ADDR_DATA_LO:
                    begin
                        if (host_status_reg[1])
                        begin
                            host_tx_next[7:0]   = wbyte;
                            host_status_next[1] = 1'b0;
                            to_dsp              = !dsp_status_reg[0];
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase

        // path transfers after the access itself
        if (to_dsp)
        begin
            dsp_rx_next         = host_tx_next;
            host_status_next[1] = 1'b1;
            dsp_status_next[0]  = 1'b1;
            result.receive_irq  = dsp_control_next[0];
        end
        if (to_host)
        begin
            host_rx_next        = dsp_tx_next;
            host_status_next[0] = 1'b1;
            dsp_status_next[1]  = 1'b1;
            result.transmit_irq = dsp_control_next[1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vector_number_reg  <= VECTOR_NUMBER_RESET;
            dsp_control_reg    <= DSP_CONTROL_RESET;
            dsp_status_reg     <= DSP_STATUS_RESET;
            host_control_reg   <= HOST_CONTROL_RESET;
            command_vector_reg <= COMMAND_VECTOR_RESET;
            host_status_reg    <= HOST_STATUS_RESET;
            host_tx_reg        <= 16'd0;
            host_rx_reg        <= 16'd0;
            dsp_tx_reg         <= 16'd0;
            dsp_rx_reg         <= 16'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                vector_number_reg <= cfg_data;
            end
            if (advance)
            begin
                dsp_control_reg    <= dsp_control_next;
                dsp_status_reg     <= dsp_status_next;
                host_control_reg   <= host_control_next;
                command_vector_reg <= command_vector_next;
                host_status_reg    <= host_status_next;
                host_tx_reg        <= host_tx_next;
                host_rx_reg        <= host_rx_next;
                dsp_tx_reg         <= dsp_tx_next;
                dsp_rx_reg         <= dsp_rx_next;
            end
        end
    end

`ifndef SYNTHESIS
    a_cmd_irq_enabled: assert property (@(posedge clk) disable iff (!rst_n)
        result.command_irq |-> dsp_control_reg[2])
        else $error("command irq without enable");
    a_rx_irq_sets_full: assert property (@(posedge clk) disable iff (!rst_n)
        advance && result.receive_irq |=> dsp_status_reg[0] && !host_status_reg[1] == 1'b0)
        else $error("receive irq without dsp word full");
    a_tx_irq_sets_full: assert property (@(posedge clk) disable iff (!rst_n)
        advance && result.transmit_irq |=> host_status_reg[0] && dsp_status_reg[1])
        else $error("transmit irq without host bytes full");
    a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(host_status_reg) && $stable(dsp_status_reg))
        else $error("flags changed with no word taken");
`endif

endmodule

// ----- rtl/core/hphr_out_stage.sv -----
`timescale 1ns / 1ps

module hphr_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  hphr_pkg::result_t result,
    output logic              space,
    hphr_out_if.source        response
);
    import hphr_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign space      = !valid_reg || response.ready;
    assign valid_next = load ? 1'b1 : (response.ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign response.valid        = valid_reg;
    assign response.read_data    = result_reg.read_data;
    assign response.command_irq  = result_reg.command_irq;
    assign response.transmit_irq = result_reg.transmit_irq;
    assign response.receive_irq  = result_reg.receive_irq;

endmodule

// ----- rtl/core/host_port_handshake_registers.sv -----
`timescale 1ns / 1ps

// channel    dir  payload
// request    in   operation, register_address, write_data
// response   out  read_data, command_irq, transmit_irq, receive_irq
// cfg        in   cfg_we, cfg_data (host vector number)
//
// one word per unstalled cycle: input register, register logic, result register
// response valid comes from the result register, loaded from the input register
// rst_n resets all flags and port registers at once, but not the stage data words
// a stalled response holds one word; the input register then takes one more

module host_port_handshake_registers (
    input  logic       clk,
    input  logic       rst_n,
    hphr_in_if.sink    request,
    hphr_out_if.source response,
    input  logic       cfg_we,
    input  logic [7:0] cfg_data
);
    import hphr_pkg::*;

    logic    held_valid;
    access_t held_access;
    result_t result;
    logic    space;
    logic    advance;

    assign advance = held_valid && space;

    hphr_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .request     (request),
        .advance     (advance),
        .held_valid  (held_valid),
        .held_access (held_access)
    );

    hphr_port_regs u_port_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .advance  (advance),
        .access   (held_access),
        .result   (result)
    );

    hphr_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance),
        .result   (result),
        .space    (space),
        .response (response)
    );

endmodule
